### design/scf_pkg.sv
// Package: shared types, constants and codes for the servo command packet framer.
`timescale 1ns / 1ps

package scf_pkg;

  // Command kinds
  localparam logic [1:0] ACT_MOVE_REL = 2'd0;
  localparam logic [1:0] ACT_MOVE_ABS = 2'd1;
  localparam logic [1:0] ACT_SET_ID   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SERVO_ID    = 2'd0;
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd1;
  localparam logic [1:0] REG_LOW_LIMIT   = 2'd2;
  localparam logic [1:0] REG_HIGH_LIMIT  = 2'd3;

  localparam logic [7:0]  RST_SERVO_ID    = 8'd1;
  localparam logic [15:0] RST_ZERO_OFFSET = 16'd512;
  localparam logic [15:0] RST_LOW_LIMIT   = 16'd0;
  localparam logic [15:0] RST_HIGH_LIMIT  = 16'd1023;

  // Packet bytes
  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] BCAST_ID    = 8'hFE;
  localparam logic [7:0] INSTR_WRITE = 8'h03;
  localparam logic [7:0] ADDR_GOAL   = 8'd30;
  localparam logic [7:0] ADDR_ID     = 8'h03;
  localparam logic [7:0] LEN_GOAL    = 8'd7;
  localparam logic [7:0] LEN_SET_ID  = 8'd4;

  localparam logic [15:0] SPEED_MAX = 16'd1023;

  // Byte positions; the checksum is the last byte of each packet
  localparam int          IDX_W        = 4;
  localparam logic [3:0]  LAST_GOAL    = 4'd10;
  localparam logic [3:0]  LAST_SET_ID  = 4'd7;

  localparam int          QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] rel_position;
    logic [15:0] abs_position;
    logic [15:0] speed;
    logic [7:0]  new_id;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } pkt_t;

  // Packet descriptor passed from classifier to serializer.
  // For a set-id packet, pos[7:0] carries the new id.
  typedef struct packed {
    logic        set_id;
    logic [7:0]  id;
    logic [15:0] pos;
    logic [15:0] spd;
  } desc_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
    logic        wen;
  } cfg_wr_t;

endpackage

### design/servo_command_packet_framer.sv
// Top level: servo command packet framer.
`timescale 1ns / 1ps

// Turns one servo command per transaction into an instruction packet sent as
// a stream of byte transactions, last_byte marking the checksum. A goal
// position packet has 11 bytes, a set-id packet 8; the serializer emits one
// byte per cycle unless the output stalls. Commands are classified on entry;
// rejected relative moves or an unused command code produce no bytes. A
// two-entry queue lets new commands enter while a packet is sent.
// Configuration writes (index 0 servo id, 1 zero offset, 2 low limit,
// 3 high limit) take effect at the next edge and belong in idle periods.

module servo_command_packet_framer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wen,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_stall,
  input  scf_pkg::cmd_t  cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output scf_pkg::pkt_t  pkt
);

  scf_pkg::cfg_wr_t cfg;
  scf_pkg::desc_t   push_desc;
  scf_pkg::desc_t   head;
  logic             push;
  logic             pop;
  logic             full;
  logic             head_valid;
  logic             cmd_take;

  assign cfg.wen   = cfg_wen;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  assign in_stall = full;
  assign cmd_take = in_valid && !full;

  scf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .push     (push),
    .desc     (push_desc)
  );

  scf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  scf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pkt        (pkt)
  );

endmodule

### design/scf_front.sv
// Command classifier: config registers, range checks, descriptor generation.
`timescale 1ns / 1ps

module scf_front (
  input  logic             clk,
  input  logic             rst,
  input  scf_pkg::cfg_wr_t cfg,
  input  scf_pkg::cmd_t    cmd,
  input  logic             cmd_take,
  output logic             push,
  output scf_pkg::desc_t   desc
);

  logic [7:0]  servo_id;
  logic [15:0] zero_offset;
  logic [15:0] low_limit;
  logic [15:0] high_limit;

  logic signed [17:0] target;
  logic               in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id    <= scf_pkg::RST_SERVO_ID;
      zero_offset <= scf_pkg::RST_ZERO_OFFSET;
      low_limit   <= scf_pkg::RST_LOW_LIMIT;
      high_limit  <= scf_pkg::RST_HIGH_LIMIT;
    end else if (cfg.wen) begin
      unique case (cfg.index)
        scf_pkg::REG_SERVO_ID:    servo_id    <= cfg.data[7:0];
        scf_pkg::REG_ZERO_OFFSET: zero_offset <= cfg.data;
        scf_pkg::REG_LOW_LIMIT:   low_limit   <= cfg.data;
        scf_pkg::REG_HIGH_LIMIT:  high_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Relative target without wrap: sign-extended offset plus unsigned zero point
  assign target = $signed({{2{cmd.rel_position[15]}}, cmd.rel_position})
                + $signed({2'b00, zero_offset});

  assign in_range = (target >= $signed({2'b00, low_limit}))
                 && (target <= $signed({2'b00, high_limit}))
                 && (cmd.speed <= scf_pkg::SPEED_MAX);

  always_comb begin
    desc.set_id = 1'b0;
    desc.id     = servo_id;
    desc.pos    = cmd.abs_position;
    desc.spd    = cmd.speed;
    push        = 1'b0;
    unique case (cmd.action)
      scf_pkg::ACT_MOVE_REL: begin
        desc.pos = target[15:0];
        push     = cmd_take && in_range;
      end
      scf_pkg::ACT_MOVE_ABS: begin
        push = cmd_take;
      end
      scf_pkg::ACT_SET_ID: begin
        desc.set_id = 1'b1;
        desc.id     = scf_pkg::BCAST_ID;
        desc.pos    = {8'd0, cmd.new_id};
        push        = cmd_take;
      end
      default: ;
    endcase
  end

endmodule

### design/scf_queue.sv
// Two-entry descriptor queue between classifier and serializer.
`timescale 1ns / 1ps

module scf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scf_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output scf_pkg::desc_t head
);

  scf_pkg::desc_t entries [scf_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'(scf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue pop while empty");
`endif

endmodule

### design/scf_back.sv
// Packet serializer: one byte per transaction, running checksum, output register.
`timescale 1ns / 1ps

module scf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  scf_pkg::desc_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output scf_pkg::pkt_t  pkt
);

  logic [scf_pkg::IDX_W-1:0] idx;
  logic [7:0]                sum;
  logic [7:0]                byte_val;
  logic [scf_pkg::IDX_W-1:0] last_idx;
  logic                      is_last;
  logic                      load;

  assign last_idx = head.set_id ? scf_pkg::LAST_SET_ID : scf_pkg::LAST_GOAL;
  assign is_last  = (idx == last_idx);
  assign load     = head_valid && (!out_valid || !out_stall);
  assign pop      = load && is_last;

  always_comb begin
    byte_val = scf_pkg::HDR_BYTE;
    if (is_last) begin
      byte_val = ~sum;
    end else if (head.set_id) begin
      unique case (idx)
        4'd2:    byte_val = scf_pkg::BCAST_ID;
        4'd3:    byte_val = scf_pkg::LEN_SET_ID;
        4'd4:    byte_val = scf_pkg::INSTR_WRITE;
        4'd5:    byte_val = scf_pkg::ADDR_ID;
        4'd6:    byte_val = head.pos[7:0];
        default: byte_val = scf_pkg::HDR_BYTE;
      endcase
    end else begin
      unique case (idx)
        4'd2:    byte_val = head.id;
        4'd3:    byte_val = scf_pkg::LEN_GOAL;
        4'd4:    byte_val = scf_pkg::INSTR_WRITE;
        4'd5:    byte_val = scf_pkg::ADDR_GOAL;
        4'd6:    byte_val = head.pos[7:0];
        4'd7:    byte_val = head.pos[15:8];
        4'd8:    byte_val = head.spd[7:0];
        4'd9:    byte_val = head.spd[15:8];
        default: byte_val = scf_pkg::HDR_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
      if (load) begin
        idx <= is_last ? '0 : idx + 4'd1;
        // header bytes stay out of the checksum
        sum <= (idx < 4'd2) ? 8'd0 : sum + byte_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt.tx_byte   <= byte_val;
      pkt.last_byte <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx <= last_idx))
    else $error("byte index past end of packet");
  a_mid_packet_head: assert property (@(posedge clk) disable iff (rst)
    (idx != 4'd0) |-> head_valid)
    else $error("packet in progress lost its descriptor");
  a_header_first: assert property (@(posedge clk) disable iff (rst)
    (load && idx == 4'd0) |=> (out_valid && pkt.tx_byte == scf_pkg::HDR_BYTE
                               && !pkt.last_byte))
    else $error("packet does not open with header byte");
`endif

endmodule
